@@ rtl/core/bsfc_pkg.sv @@
// ----------------------------------------------------------------------------
// bsfc_pkg
// shared types, codes and constants of the byte stream feature counter
// ----------------------------------------------------------------------------
package bsfc_pkg;

    // default counter width
    localparam int COUNT_BITS_DEF = 32;

    // fixed field widths
    localparam int OUT_W     = 48;
    localparam int UNI_AW    = 8;
    localparam int PAIR_AW   = 16;
    localparam int OP_W      = 3;
    localparam int SEL_W     = 4;
    localparam int IN_DATA_W = 32;

    // byte classes and byte size
    localparam logic [7:0] LOW_LIMIT  = 8'h20;
    localparam logic [7:0] HIGH_LIMIT = 8'h80;
    localparam int         BYTE_BITS  = 8;

    // request opcodes
    localparam logic [OP_W-1:0] OP_ADD     = 3'd0;
    localparam logic [OP_W-1:0] OP_CLEAR   = 3'd1;
    localparam logic [OP_W-1:0] OP_RD_UNI  = 3'd2;
    localparam logic [OP_W-1:0] OP_RD_PAIR = 3'd3;
    localparam logic [OP_W-1:0] OP_RD_STAT = 3'd4;

    // scalar selects
    localparam logic [SEL_W-1:0] STAT_BYTES   = 4'd0;
    localparam logic [SEL_W-1:0] STAT_ZEROS   = 4'd1;
    localparam logic [SEL_W-1:0] STAT_SUM     = 4'd2;
    localparam logic [SEL_W-1:0] STAT_SQUARES = 4'd3;
    localparam logic [SEL_W-1:0] STAT_CONTIG  = 4'd4;
    localparam logic [SEL_W-1:0] STAT_MAX_RUN = 4'd5;
    localparam logic [SEL_W-1:0] STAT_LOW     = 4'd6;
    localparam logic [SEL_W-1:0] STAT_MID     = 4'd7;
    localparam logic [SEL_W-1:0] STAT_HIGH    = 4'd8;

    // byte class indexes
    localparam logic [1:0] CLS_LOW  = 2'd0;
    localparam logic [1:0] CLS_MID  = 2'd1;
    localparam logic [1:0] CLS_HIGH = 2'd2;

    // strobes from the sequencer to the scalar block
    typedef struct packed {
        logic add;
        logic clear;
        logic mem_sat;
    } t_scalar_ctrl;

    // zero bits in one byte
    function automatic logic [3:0] zero_bits(input logic [7:0] b);
        logic [3:0] n;
        n = 4'(BYTE_BITS);
        for (int i = 0; i < BYTE_BITS; i++) begin
            n = n - 4'(b[i]);
        end
        return n;
    endfunction

endpackage

@@ rtl/core/bsfc_ram.sv @@
// ----------------------------------------------------------------------------
// bsfc_ram
// single port write, single port read memory with registered read data
// ----------------------------------------------------------------------------
module bsfc_ram #(
    parameter int ADDR_BITS = 8,
    parameter int DATA_BITS = 32
) (
    input  logic                 i_clk,
    input  logic                 i_wr_en,
    input  logic [ADDR_BITS-1:0] i_wr_addr,
    input  logic [DATA_BITS-1:0] i_wr_data,
    input  logic                 i_rd_en,
    input  logic [ADDR_BITS-1:0] i_rd_addr,
    output logic [DATA_BITS-1:0] o_rd_data
);

    logic [DATA_BITS-1:0] mem [2**ADDR_BITS];

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            o_rd_data <= mem[i_rd_addr];
        end
    end

endmodule

@@ rtl/core/bsfc_satadd.sv @@
// ----------------------------------------------------------------------------
// bsfc_satadd
// saturating unsigned add with ceiling detect
// ----------------------------------------------------------------------------
module bsfc_satadd #(
    parameter int WIDTH     = 32,
    parameter int INC_WIDTH = 1
) (
    input  logic [WIDTH-1:0]     i_value,
    input  logic [INC_WIDTH-1:0] i_inc,
    output logic [WIDTH-1:0]     o_sum,
    output logic                 o_at_top
);

    logic [WIDTH:0] sum;

    always_comb begin
        sum      = {1'b0, i_value} + (WIDTH+1)'(i_inc);
        o_sum    = sum[WIDTH] ? {WIDTH{1'b1}} : sum[WIDTH-1:0];
        o_at_top = &o_sum;
    end

endmodule

@@ rtl/core/bsfc_scalars.sv @@
// ----------------------------------------------------------------------------
// bsfc_scalars
// scalar sums, run tracking, byte classes and saturation flag
// ----------------------------------------------------------------------------
module bsfc_scalars import bsfc_pkg::*; #(
    parameter int COUNT_BITS = COUNT_BITS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_scalar_ctrl       i_ctrl,
    input  logic [7:0]         i_byte,
    input  logic [SEL_W-1:0]   i_sel,
    output logic               o_pair_phase,
    output logic [7:0]         o_prev_byte,
    output logic [OUT_W-1:0]   o_stat_value,
    output logic               o_sat_next
);

    localparam int ZW = COUNT_BITS + 3;
    localparam int VW = COUNT_BITS + 8;
    localparam int SW = COUNT_BITS + 16;
    localparam int DW = COUNT_BITS + 8;

    logic [COUNT_BITS-1:0] r_bytes;
    logic [ZW-1:0]         r_zero;
    logic [VW-1:0]         r_vsum;
    logic [SW-1:0]         r_sqsum;
    logic [DW-1:0]         r_dsum;
    logic [COUNT_BITS-1:0] r_run;
    logic [COUNT_BITS-1:0] r_longest;
    logic [7:0]            r_prev;
    logic [COUNT_BITS-1:0] r_class [3];
    logic                  r_phase;
    logic                  r_sat;

    logic [COUNT_BITS-1:0] bytes_sum, run_sum, class_sum, n_run;
    logic [ZW-1:0]         zero_sum;
    logic [VW-1:0]         vsum_sum;
    logic [SW-1:0]         sq_sum;
    logic [DW-1:0]         d_sum;
    logic                  bytes_top, run_top, class_top, zero_top, vsum_top, sq_top, d_top;
    logic [7:0]            diff;
    logic [15:0]           square;
    logic [3:0]            zeros;
    logic [1:0]            cls;
    logic                  run_live, same, upd_longest;
    logic                  n_sat;

    always_comb begin
        diff     = (i_byte > r_prev) ? i_byte - r_prev : r_prev - i_byte;
        square   = 16'(i_byte) * 16'(i_byte);
        zeros    = zero_bits(i_byte);
        if (i_byte < LOW_LIMIT) begin
            cls = CLS_LOW;
        end else if (i_byte < HIGH_LIMIT) begin
            cls = CLS_MID;
        end else begin
            cls = CLS_HIGH;
        end
        run_live    = (r_run != '0);
        same        = run_live && (r_prev == i_byte);
        n_run       = same ? run_sum : COUNT_BITS'(1);
        upd_longest = (n_run > r_longest);
    end

    bsfc_satadd #(.WIDTH(COUNT_BITS), .INC_WIDTH(1)) u_bytes (
        .i_value(r_bytes), .i_inc(1'b1), .o_sum(bytes_sum), .o_at_top(bytes_top)
    );
    bsfc_satadd #(.WIDTH(COUNT_BITS), .INC_WIDTH(1)) u_run (
        .i_value(r_run), .i_inc(1'b1), .o_sum(run_sum), .o_at_top(run_top)
    );
    bsfc_satadd #(.WIDTH(COUNT_BITS), .INC_WIDTH(1)) u_class (
        .i_value(r_class[cls]), .i_inc(1'b1), .o_sum(class_sum), .o_at_top(class_top)
    );
    bsfc_satadd #(.WIDTH(ZW), .INC_WIDTH(4)) u_zero (
        .i_value(r_zero), .i_inc(zeros), .o_sum(zero_sum), .o_at_top(zero_top)
    );
    bsfc_satadd #(.WIDTH(VW), .INC_WIDTH(8)) u_vsum (
        .i_value(r_vsum), .i_inc(i_byte), .o_sum(vsum_sum), .o_at_top(vsum_top)
    );
    bsfc_satadd #(.WIDTH(SW), .INC_WIDTH(16)) u_sq (
        .i_value(r_sqsum), .i_inc(square), .o_sum(sq_sum), .o_at_top(sq_top)
    );
    bsfc_satadd #(.WIDTH(DW), .INC_WIDTH(8)) u_diff (
        .i_value(r_dsum), .i_inc(diff), .o_sum(d_sum), .o_at_top(d_top)
    );

    // flag after this request
    always_comb begin
        if (i_ctrl.clear) begin
            n_sat = 1'b0;
        end else if (i_ctrl.add) begin
            n_sat = r_sat | i_ctrl.mem_sat | bytes_top | zero_top | vsum_top | sq_top
                  | class_top | (run_live & d_top) | (same & run_top)
                  | (upd_longest & (&n_run));
        end else begin
            n_sat = r_sat;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_ctrl.clear) begin
            r_bytes    <= '0;
            r_zero     <= '0;
            r_vsum     <= '0;
            r_sqsum    <= '0;
            r_dsum     <= '0;
            r_run      <= '0;
            r_longest  <= '0;
            r_prev     <= '0;
            r_class[0] <= '0;
            r_class[1] <= '0;
            r_class[2] <= '0;
            r_phase    <= 1'b0;
            r_sat      <= 1'b0;
        end else begin
            r_sat <= n_sat;
            if (i_ctrl.add) begin
                r_bytes <= bytes_sum;
                r_zero  <= zero_sum;
                r_vsum  <= vsum_sum;
                r_sqsum <= sq_sum;
                if (run_live) begin
                    r_dsum <= d_sum;
                end
                r_run  <= n_run;
                r_prev <= i_byte;
                if (upd_longest) begin
                    r_longest <= n_run;
                end
                r_class[cls] <= class_sum;
                r_phase      <= ~r_phase;
            end
        end
    end

    always_comb begin
        case (i_sel)
            STAT_BYTES:   o_stat_value = OUT_W'(r_bytes);
            STAT_ZEROS:   o_stat_value = OUT_W'(r_zero);
            STAT_SUM:     o_stat_value = OUT_W'(r_vsum);
            STAT_SQUARES: o_stat_value = OUT_W'(r_sqsum);
            STAT_CONTIG:  o_stat_value = OUT_W'(r_dsum);
            STAT_MAX_RUN: o_stat_value = OUT_W'(r_longest);
            STAT_LOW:     o_stat_value = OUT_W'(r_class[0]);
            STAT_MID:     o_stat_value = OUT_W'(r_class[1]);
            STAT_HIGH:    o_stat_value = OUT_W'(r_class[2]);
            default:      o_stat_value = '0;
        endcase
    end

    assign o_pair_phase = r_phase;
    assign o_prev_byte  = r_prev;
    assign o_sat_next   = n_sat;

endmodule

@@ rtl/core/byte_stream_feature_counter_top.sv @@
// ----------------------------------------------------------------------------
// byte_stream_feature_counter_top
// byte histogram, pair histogram and scalar feature counter
// ----------------------------------------------------------------------------
// usage
//   s_axis carries one request: tuser is the opcode (add byte, clear, read
//   unigram bin, read pair bin, read scalar), tdata the byte, bin and select
//   m_axis returns exactly one result per request: tdata the read value,
//   tuser the saturation flag after the request
// request flow
//   a request is a histogram memory read on acceptance, then modify, write
//   back and result register load; a new request is taken only after the
//   last one is written back, since the histogram memories have a single
//   read-modify-write slot
// reset and clear
//   after reset the pair and unigram memories are zeroed by a sweep over
//   all 65536 pair entries, one pair entry per cycle, with tready low; a
//   clear request returns its result and then runs the same sweep
// stall behaviour
//   the result register holds while m_axis_tready is low; the next request
//   is still taken and waits in its write-back step until the register frees
// ----------------------------------------------------------------------------
module byte_stream_feature_counter_top import bsfc_pkg::*; #(
    parameter int COUNT_BITS = COUNT_BITS_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    input  logic [IN_DATA_W-1:0] s_axis_tdata,  // data_byte, bin_index, stat_select
    input  logic [OP_W-1:0]      s_axis_tuser,  // opcode
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    output logic [OUT_W-1:0]     m_axis_tdata,  // read_value
    output logic                 m_axis_tuser   // saturated
);

    typedef enum logic [2:0] {
        ST_IDLE  = 3'b001,
        ST_EXEC  = 3'b010,
        ST_SWEEP = 3'b100
    } t_state;

    t_state                r_state, n_state;
    logic [OP_W-1:0]       r_op;
    logic [7:0]            r_byte;
    logic [SEL_W-1:0]      r_sel;
    logic [PAIR_AW-1:0]    r_pair_addr;
    logic                  r_pair_phase;
    logic [PAIR_AW-1:0]    r_sweep_addr;
    logic                  r_out_valid;
    logic [OUT_W-1:0]      r_out_value;
    logic                  r_out_sat;

    // request fields
    logic [7:0]            in_byte;
    logic [PAIR_AW-1:0]    in_bin;
    logic [SEL_W-1:0]      in_sel;
    logic                  accept, exec, commit, sweep, is_add;

    // memory ports
    logic [UNI_AW-1:0]     uni_rd_addr, uni_wr_addr;
    logic [PAIR_AW-1:0]    pair_rd_addr, pair_wr_addr;
    logic [COUNT_BITS-1:0] uni_rd_data, pair_rd_data;
    logic [COUNT_BITS-1:0] uni_sum, pair_sum, uni_wr_data, pair_wr_data;
    logic                  uni_top, pair_top, uni_wr_en, pair_wr_en;

    // scalar block
    t_scalar_ctrl          sc_ctrl;
    logic                  pair_phase, sat_next;
    logic [7:0]            prev_byte;
    logic [OUT_W-1:0]      stat_value;
    logic [OUT_W-1:0]      result;

    assign in_byte = s_axis_tdata[7:0];
    assign in_bin  = s_axis_tdata[23:8];
    assign in_sel  = s_axis_tdata[27:24];

    assign s_axis_tready = (r_state == ST_IDLE);
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign exec          = (r_state == ST_EXEC);
    assign sweep         = (r_state == ST_SWEEP);
    // write-back only once the result register is free
    assign commit        = exec && (!r_out_valid || m_axis_tready);
    assign is_add        = (r_op == OP_ADD);

    // histogram reads on acceptance
    assign uni_rd_addr  = (s_axis_tuser == OP_RD_UNI) ? in_bin[UNI_AW-1:0] : in_byte;
    assign pair_rd_addr = (s_axis_tuser == OP_RD_PAIR) ? in_bin : {prev_byte, in_byte};

    bsfc_satadd #(.WIDTH(COUNT_BITS), .INC_WIDTH(1)) u_uni_inc (
        .i_value(uni_rd_data), .i_inc(1'b1), .o_sum(uni_sum), .o_at_top(uni_top)
    );
    bsfc_satadd #(.WIDTH(COUNT_BITS), .INC_WIDTH(1)) u_pair_inc (
        .i_value(pair_rd_data), .i_inc(1'b1), .o_sum(pair_sum), .o_at_top(pair_top)
    );

    // write-back or clearing sweep
    always_comb begin
        uni_wr_en    = sweep || (commit && is_add);
        uni_wr_addr  = sweep ? r_sweep_addr[UNI_AW-1:0] : r_byte;
        uni_wr_data  = sweep ? '0 : uni_sum;
        // a pair is counted when its second byte arrives
        pair_wr_en   = sweep || (commit && is_add && r_pair_phase);
        pair_wr_addr = sweep ? r_sweep_addr : r_pair_addr;
        pair_wr_data = sweep ? '0 : pair_sum;
    end

    bsfc_ram #(.ADDR_BITS(UNI_AW), .DATA_BITS(COUNT_BITS)) u_uni_ram (
        .i_clk     (i_clk),
        .i_wr_en   (uni_wr_en),
        .i_wr_addr (uni_wr_addr),
        .i_wr_data (uni_wr_data),
        .i_rd_en   (accept),
        .i_rd_addr (uni_rd_addr),
        .o_rd_data (uni_rd_data)
    );

    bsfc_ram #(.ADDR_BITS(PAIR_AW), .DATA_BITS(COUNT_BITS)) u_pair_ram (
        .i_clk     (i_clk),
        .i_wr_en   (pair_wr_en),
        .i_wr_addr (pair_wr_addr),
        .i_wr_data (pair_wr_data),
        .i_rd_en   (accept),
        .i_rd_addr (pair_rd_addr),
        .o_rd_data (pair_rd_data)
    );

    always_comb begin
        sc_ctrl.add     = commit && is_add;
        sc_ctrl.clear   = commit && (r_op == OP_CLEAR);
        sc_ctrl.mem_sat = uni_top || (r_pair_phase && pair_top);
    end

    bsfc_scalars #(.COUNT_BITS(COUNT_BITS)) u_scalars (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_ctrl       (sc_ctrl),
        .i_byte       (r_byte),
        .i_sel        (r_sel),
        .o_pair_phase (pair_phase),
        .o_prev_byte  (prev_byte),
        .o_stat_value (stat_value),
        .o_sat_next   (sat_next)
    );

    // result select
    always_comb begin
        case (r_op)
            OP_RD_UNI:  result = OUT_W'(uni_rd_data);
            OP_RD_PAIR: result = OUT_W'(pair_rd_data);
            OP_RD_STAT: result = stat_value;
            default:    result = '0;
        endcase
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    n_state = ST_EXEC;
                end
            end
            ST_EXEC: begin
                if (commit) begin
                    n_state = (r_op == OP_CLEAR) ? ST_SWEEP : ST_IDLE;
                end
            end
            ST_SWEEP: begin
                if (&r_sweep_addr) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_SWEEP;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_SWEEP;
            r_sweep_addr <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state <= n_state;
            if (sweep) begin
                r_sweep_addr <= r_sweep_addr + PAIR_AW'(1);
            end else if (commit) begin
                r_sweep_addr <= '0;
            end
            if (commit) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // request and result payload
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_op         <= s_axis_tuser;
            r_byte       <= in_byte;
            r_sel        <= in_sel;
            r_pair_addr  <= {prev_byte, in_byte};
            r_pair_phase <= pair_phase;
        end
        if (commit) begin
            r_out_value <= result;
            r_out_sat   <= sat_next;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_value;
    assign m_axis_tuser  = r_out_sat;

endmodule

@@ rtl/core/bsfc_checker.sv @@
// ----------------------------------------------------------------------------
// bsfc_checker
// port-level checks of the feature counter, bound to the top level
// ----------------------------------------------------------------------------
module bsfc_checker import bsfc_pkg::*; (
    input logic                 i_clk,
    input logic                 i_rst_n,
    input logic                 s_axis_tvalid,
    input logic                 s_axis_tready,
    input logic [IN_DATA_W-1:0] s_axis_tdata,
    input logic [OP_W-1:0]      s_axis_tuser,
    input logic                 m_axis_tvalid,
    input logic                 m_axis_tready,
    input logic [OUT_W-1:0]     m_axis_tdata,
    input logic                 m_axis_tuser
);

    // reset starts the clearing sweep
    a_reset_sweep: assert property (@(posedge i_clk)
        !i_rst_n |=> !s_axis_tready)
        else $error("request taken right after reset");

    // one request in flight at a time
    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
        else $error("second request taken during write-back");

    // a new result only follows a busy cycle
    a_result_after_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(m_axis_tvalid) |-> !$past(s_axis_tready))
        else $error("result without a request in work");

    // stalled result holds
    a_result_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tready) |=>
            (m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser)))
        else $error("stalled result changed");

endmodule

bind byte_stream_feature_counter_top bsfc_checker u_bsfc_checker (.*);

@@ bench/feature_counter_checker.sv @@
// ----------------------------------------------------------------------------
// feature_counter_checker
// watches both stream channels, predicts every result and compares it
// ----------------------------------------------------------------------------
module feature_counter_checker import bsfc_pkg::*; #(
    parameter int COUNT_BITS = COUNT_BITS_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_req_valid,
    input  logic                 i_req_ready,
    input  logic [IN_DATA_W-1:0] i_req_data,  // data_byte, bin_index, stat_select
    input  logic [OP_W-1:0]      i_req_op,
    input  logic                 i_res_valid,
    input  logic                 i_res_ready,
    input  logic [OUT_W-1:0]     i_res_data,  // read_value
    input  logic                 i_res_sat,
    output int                   o_fail_count,
    output int                   o_pending
);

    localparam int CB   = COUNT_BITS;
    localparam int ZB_W = COUNT_BITS + 3;
    localparam int VS_W = COUNT_BITS + 8;
    localparam int SQ_W = COUNT_BITS + 16;
    localparam int MAX_REPORTS = 10;

    typedef struct packed {
        logic [OUT_W-1:0] value;
        logic             sat;
    } t_feature_result;

    // predicted feature state
    logic [CB-1:0]   uni_tally [256];
    logic [CB-1:0]   pair_tally [65536];
    logic [CB-1:0]   class_tally [3];
    logic [CB-1:0]   byte_tally;
    logic [CB-1:0]   run_len;
    logic [CB-1:0]   longest_run;
    logic [ZB_W-1:0] zero_bit_total;
    logic [VS_W-1:0] value_total;
    logic [VS_W-1:0] diff_total;
    logic [SQ_W-1:0] square_total;
    logic [7:0]      prev_byte;
    logic            sat_seen;
    logic            pair_second;

    t_feature_result awaited_results [$];
    t_feature_result want;
    t_feature_result got;
    int              fault_total = 0;
    int              pending_total = 0;

    assign o_fail_count = fault_total;
    assign o_pending    = pending_total;

    function automatic void wipe_features();
        for (int i = 0; i < 256; i++) uni_tally[i] = '0;
        for (int i = 0; i < 65536; i++) pair_tally[i] = '0;
        for (int i = 0; i < 3; i++) class_tally[i] = '0;
        byte_tally     = '0;
        run_len        = '0;
        longest_run    = '0;
        zero_bit_total = '0;
        value_total    = '0;
        diff_total     = '0;
        square_total   = '0;
        prev_byte      = '0;
        sat_seen       = 1'b0;
        pair_second    = 1'b0;
    endfunction

    // saturating add at the given width, flags a counter that reaches its ceiling
    function automatic logic [63:0] bump(input logic [63:0] v, input logic [63:0] inc,
                                         input int bits);
        logic [63:0] ceil_v;
        logic [63:0] r;
        ceil_v = (64'd1 << bits) - 64'd1;
        r = (v > ceil_v - inc) ? ceil_v : v + inc;
        if (r == ceil_v) sat_seen = 1'b1;
        return r;
    endfunction

    function automatic void take_byte(input logic [7:0] b);
        logic [7:0] d;
        logic [1:0] cls;
        uni_tally[b] = CB'(bump(64'(uni_tally[b]), 64'd1, CB));
        // a pair is counted on its second byte
        if (pair_second)
            pair_tally[{prev_byte, b}] = CB'(bump(64'(pair_tally[{prev_byte, b}]), 64'd1, CB));
        pair_second = !pair_second;
        // no difference for the first byte after clear
        if (run_len != '0) begin
            d = (b > prev_byte) ? b - prev_byte : prev_byte - b;
            diff_total = VS_W'(bump(64'(diff_total), 64'(d), VS_W));
        end
        if (run_len != '0 && prev_byte == b)
            run_len = CB'(bump(64'(run_len), 64'd1, CB));
        else
            run_len = CB'(1);
        prev_byte = b;
        if (run_len > longest_run) begin
            longest_run = run_len;
            if (&longest_run) sat_seen = 1'b1;
        end
        zero_bit_total = ZB_W'(bump(64'(zero_bit_total), 64'(BYTE_BITS - $countones(b)), ZB_W));
        value_total    = VS_W'(bump(64'(value_total), 64'(b), VS_W));
        square_total   = SQ_W'(bump(64'(square_total), 64'(b) * 64'(b), SQ_W));
        byte_tally     = CB'(bump(64'(byte_tally), 64'd1, CB));
        if (b < LOW_LIMIT)
            cls = CLS_LOW;
        else if (b < HIGH_LIMIT)
            cls = CLS_MID;
        else
            cls = CLS_HIGH;
        class_tally[cls] = CB'(bump(64'(class_tally[cls]), 64'd1, CB));
    endfunction

    function automatic logic [63:0] scalar_of(input logic [SEL_W-1:0] sel);
        case (sel)
            STAT_BYTES:   return 64'(byte_tally);
            STAT_ZEROS:   return 64'(zero_bit_total);
            STAT_SUM:     return 64'(value_total);
            STAT_SQUARES: return 64'(square_total);
            STAT_CONTIG:  return 64'(diff_total);
            STAT_MAX_RUN: return 64'(longest_run);
            STAT_LOW:     return 64'(class_tally[CLS_LOW]);
            STAT_MID:     return 64'(class_tally[CLS_MID]);
            STAT_HIGH:    return 64'(class_tally[CLS_HIGH]);
            default:      return 64'd0;
        endcase
    endfunction

    function automatic t_feature_result serve_request(input logic [OP_W-1:0] op,
                                                      input logic [IN_DATA_W-1:0] data);
        logic [7:0]       b;
        logic [15:0]      bin;
        logic [SEL_W-1:0] sel;
        logic [63:0]      value;
        t_feature_result  res;
        b     = data[7:0];
        bin   = data[23:8];
        sel   = data[27:24];
        value = 64'd0;
        case (op)
            OP_ADD:     take_byte(b);
            OP_CLEAR:   wipe_features();
            OP_RD_UNI:  value = 64'(uni_tally[bin[7:0]]);
            OP_RD_PAIR: value = 64'(pair_tally[bin]);
            OP_RD_STAT: value = scalar_of(sel);
            default:    ;
        endcase
        res.value = OUT_W'(value);
        res.sat   = sat_seen;
        return res;
    endfunction

    initial wipe_features();

    // results first, so a result never pairs with a request taken at the same edge
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_res_valid && i_res_ready) begin
                got.value = i_res_data;
                got.sat   = i_res_sat;
                if (awaited_results.size() == 0) begin
                    if (fault_total < MAX_REPORTS)
                        $display("%0t: unexpected result value %h sat %b",
                                 $realtime, got.value, got.sat);
                    fault_total++;
                end else begin
                    want = awaited_results.pop_front();
                    if (got !== want) begin
                        if (fault_total < MAX_REPORTS)
                            $display("%0t: mismatch: expected value %h sat %b, got value %h sat %b",
                                     $realtime, want.value, want.sat, got.value, got.sat);
                        fault_total++;
                    end
                end
            end
            if (i_req_valid && i_req_ready)
                awaited_results.push_back(serve_request(i_req_op, i_req_data));
            pending_total <= awaited_results.size();
        end
    end

endmodule

@@ bench/byte_stream_feature_counter_top_test.sv @@
// ----------------------------------------------------------------------------
// byte_stream_feature_counter_top_test
// directed and random requests to the feature counter under varied back-pressure
// ----------------------------------------------------------------------------
module byte_stream_feature_counter_top_test;
    import bsfc_pkg::*;

    localparam int CYCLE_LIMIT  = 3_000_000;  // reset sweep, four clear sweeps, stalls, many times over
    localparam int SEGMENTS     = 8;
    localparam int SEG_REQUESTS = 194;
    localparam int TAIL_CYCLES  = 8;
    localparam int HISTORY      = 8;

    // first and last opcode with no function
    localparam logic [OP_W-1:0] OP_SPARE_LO = OP_RD_STAT + 1'b1;
    localparam logic [OP_W-1:0] OP_SPARE_HI = '1;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 s_axis_tvalid = 1'b0;
    logic                 s_axis_tready;
    logic [IN_DATA_W-1:0] s_axis_tdata = '0;   // data_byte, bin_index, stat_select
    logic [OP_W-1:0]      s_axis_tuser = '0;   // opcode
    logic                 m_axis_tvalid;
    logic                 m_axis_tready = 1'b0;
    logic [OUT_W-1:0]     m_axis_tdata;        // read_value
    logic                 m_axis_tuser;        // saturated

    int fail_count;
    int pending;
    int gap_pct = 0;     // chance per cycle that the sender holds back
    int stall_pct = 0;   // chance per cycle that the receiver stalls
    int cycle_count = 0;

    logic [7:0] recent_bytes [$];  // last bytes added, used to aim reads at live bins

    always #4 clk = ~clk;

    byte_stream_feature_counter_top dut (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    feature_counter_checker checker_i (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_req_valid  (s_axis_tvalid),
        .i_req_ready  (s_axis_tready),
        .i_req_data   (s_axis_tdata),
        .i_req_op     (s_axis_tuser),
        .i_res_valid  (m_axis_tvalid),
        .i_res_ready  (m_axis_tready),
        .i_res_data   (m_axis_tdata),
        .i_res_sat    (m_axis_tuser),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    // receiver back-pressure, redrawn every cycle
    always @(posedge clk) begin
        m_axis_tready <= ($urandom_range(99) >= stall_pct);
    end

    // watchdog
    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    // one request: random idle cycles first, then hold valid until it is taken
    task automatic send_request(input logic [OP_W-1:0] op, input logic [7:0] b,
                                input logic [15:0] bin, input logic [SEL_W-1:0] sel);
        while ($urandom_range(99) < gap_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= op;
        s_axis_tdata  <= IN_DATA_W'({sel, bin, b});
        @(posedge clk);
        while (!s_axis_tready) @(posedge clk);
        if (op == OP_ADD) begin
            recent_bytes.push_back(b);
            if (recent_bytes.size() > HISTORY) void'(recent_bytes.pop_front());
        end
    endtask

    // a byte that tends to extend runs, hit class edges, or is just random
    function automatic logic [7:0] pick_byte();
        int r;
        r = $urandom_range(99);
        if (r < 35 && recent_bytes.size() != 0)
            return recent_bytes[recent_bytes.size() - 1];
        if (r < 60) begin
            case ($urandom_range(5))
                0:       return 8'h00;
                1:       return 8'h1f;
                2:       return 8'h20;
                3:       return 8'h7f;
                4:       return 8'h80;
                default: return 8'hff;
            endcase
        end
        return 8'($urandom);
    endfunction

    // a byte that was seen lately, or a random one now and then
    function automatic logic [7:0] seen_byte();
        if (recent_bytes.size() == 0 || $urandom_range(3) == 0)
            return 8'($urandom);
        return recent_bytes[$urandom_range(recent_bytes.size() - 1)];
    endfunction

    task automatic random_request();
        int               pick;
        logic [SEL_W-1:0] sel;
        pick = $urandom_range(99);
        if ($urandom_range(7) == 0)
            sel = SEL_W'($urandom_range(2**SEL_W - 1, STAT_HIGH + 1));
        else
            sel = SEL_W'($urandom_range(STAT_HIGH, STAT_BYTES));
        if (pick < 55)
            send_request(OP_ADD, pick_byte(), 16'($urandom), SEL_W'($urandom));
        else if (pick < 68)
            // upper index bits are junk for a unigram read
            send_request(OP_RD_UNI, 8'($urandom), {8'($urandom), seen_byte()}, SEL_W'($urandom));
        else if (pick < 80)
            send_request(OP_RD_PAIR, 8'($urandom), {seen_byte(), seen_byte()}, SEL_W'($urandom));
        else if (pick < 96)
            send_request(OP_RD_STAT, 8'($urandom), 16'($urandom), sel);
        else
            send_request(OP_W'($urandom_range(OP_SPARE_HI, OP_SPARE_LO)), 8'($urandom),
                         16'($urandom), SEL_W'($urandom));
    endtask

    initial begin
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        // directed part, no idling on either side
        // pairs 00/ff, ff/ff and 1f/20; a run of three ff; every class edge
        send_request(OP_ADD, 8'h00, 16'h0000, STAT_BYTES);
        send_request(OP_ADD, 8'hff, 16'hffff, STAT_HIGH);
        send_request(OP_ADD, 8'hff, 16'h0000, STAT_BYTES);
        send_request(OP_ADD, 8'hff, 16'hffff, STAT_HIGH);
        send_request(OP_ADD, 8'h1f, 16'h5a5a, STAT_SUM);
        send_request(OP_ADD, 8'h20, 16'ha5a5, STAT_SUM);
        send_request(OP_ADD, 8'h80, 16'h0000, STAT_BYTES);
        send_request(OP_RD_PAIR, 8'h00, 16'h00ff, STAT_BYTES);
        send_request(OP_RD_PAIR, 8'hff, 16'hffff, STAT_BYTES);
        // unigram read with high index bits set, only the low byte counts
        send_request(OP_RD_UNI, 8'h00, 16'hab20, STAT_BYTES);
        for (int s = STAT_BYTES; s <= STAT_HIGH; s++)
            send_request(OP_RD_STAT, 8'h00, 16'h0000, SEL_W'(s));
        // select beyond the last scalar reads as zero
        send_request(OP_RD_STAT, 8'hff, 16'hffff, SEL_W'(2**SEL_W - 1));
        // spare opcode has no effect
        send_request(OP_SPARE_HI, 8'hff, 16'hffff, SEL_W'(2**SEL_W - 1));
        // first byte after clear adds no difference and starts a run of one
        send_request(OP_CLEAR, 8'h00, 16'h0000, STAT_BYTES);
        send_request(OP_ADD, 8'h55, 16'h0000, STAT_BYTES);
        send_request(OP_RD_STAT, 8'h00, 16'h0000, STAT_CONTIG);
        send_request(OP_RD_STAT, 8'h00, 16'h0000, STAT_MAX_RUN);

        // random part, idling mode changes per segment, a clear now and then
        for (int seg = 0; seg < SEGMENTS; seg++) begin
            case (seg % 4)
                0:       begin gap_pct = 0;  stall_pct = 0;  end
                1:       begin gap_pct = 56; stall_pct = 0;  end
                2:       begin gap_pct = 0;  stall_pct = 56; end
                default: begin gap_pct = 34; stall_pct = 34; end
            endcase
            if (seg % 2 == 0 && seg != 0) begin
                send_request(OP_CLEAR, 8'($urandom), 16'($urandom), SEL_W'($urandom));
                recent_bytes.delete();
            end
            repeat (SEG_REQUESTS) random_request();
        end
        s_axis_tvalid <= 1'b0;

        // let the last request reach the checker, then drain and settle
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);

        if (fail_count == 0 && pending == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

@@ sim.f @@
rtl/core/bsfc_pkg.sv
rtl/core/bsfc_ram.sv
rtl/core/bsfc_satadd.sv
rtl/core/bsfc_scalars.sv
rtl/core/byte_stream_feature_counter_top.sv
rtl/core/bsfc_checker.sv
bench/feature_counter_checker.sv
bench/byte_stream_feature_counter_top_test.sv
